/* rtl/max_flow_augmenting_paths_top_macros.svh */
// Assertion macros shared by the flow block.
`ifndef MAX_FLOW_AUGMENTING_PATHS_TOP_MACROS_SVH
`define MAX_FLOW_AUGMENTING_PATHS_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define MFAP_ASSERT_SAME(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("flow block check failed");
`define MFAP_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("flow block check failed");
`else
`define MFAP_ASSERT_SAME(name, clk, rst, ante, cons)
`define MFAP_ASSERT_NEXT(name, clk, rst, ante, cons)
`endif

`endif

/* rtl/mfap_pkg.sv */
package mfap_pkg;

   localparam int MAX_NODES_DEF     = 64;
   localparam int EDGE_CAP_BITS_DEF = 16;
   localparam int NODE_FIELD_W      = 6;
   localparam int CAP_FIELD_W       = 16;
   localparam int CSR_IDX_W         = 2;
   localparam int CSR_DATA_W        = 7;
   localparam int CELL_W            = 25;
   localparam int FLOW_W            = 30;

   localparam logic [CELL_W-1:0] CELL_MAX = '1;
   localparam logic [FLOW_W-1:0] FLOW_MAX = '1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_NODE_COUNT  = 2'd0,
      CSR_SOURCE_NODE = 2'd1,
      CSR_SINK_NODE   = 2'd2
   } csr_index_type;

   typedef enum logic [4:0] {
      OP_IDLE,
      OP_CLEAR,
      OP_LOAD,
      OP_START,
      OP_BFS_INIT,
      OP_DEQ,
      OP_DEQ_WAIT,
      OP_SCAN_RD,
      OP_SCAN_EV,
      OP_BN_P,
      OP_BN_PW,
      OP_BN_C,
      OP_AUG_P,
      OP_AUG_PW,
      OP_AUG_W1,
      OP_AUG_W2,
      OP_FINISH
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
      logic      load_fire;
   } dp_cmd_type;

   typedef struct packed {
      logic clear_done;
      logic queue_empty;
      logic scan_last;
      logic found;
      logic at_src;
      logic trivial;
   } dp_status_type;

endpackage

/* rtl/mfap_dp.sv */
module mfap_dp import mfap_pkg::*; #(
   parameter int MAX_NODES     = MAX_NODES_DEF,
   parameter int EDGE_CAP_BITS = EDGE_CAP_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  dp_cmd_type              cmd,
   output dp_status_type           status,
   input  logic                    csr_wr_en,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_wdata,
   input  logic [NODE_FIELD_W-1:0] req_edge_from,
   input  logic [NODE_FIELD_W-1:0] req_edge_to,
   input  logic [CAP_FIELD_W-1:0]  req_edge_capacity,
   output logic [FLOW_W-1:0]       rsp_max_flow
);

   localparam int NW = $clog2(MAX_NODES);
   localparam int AW = 2 * NW;
   localparam int CW = $clog2(MAX_NODES + 1);
   localparam logic [CAP_FIELD_W-1:0] CAP_MASK = (EDGE_CAP_BITS >= CAP_FIELD_W) ?
      '1 : CAP_FIELD_W'((1 << EDGE_CAP_BITS) - 1);

   // Configuration registers.
   logic [CSR_DATA_W-1:0]   node_count_ff;
   logic [NODE_FIELD_W-1:0] src_ff;
   logic [NODE_FIELD_W-1:0] dst_ff;

   // Residual capacity memory and its ports.
   logic [CELL_W-1:0] cell_mem [2**AW];
   logic [CELL_W-1:0] cell_rd_ff;
   logic [AW-1:0]     cell_raddr;
   logic [AW-1:0]     cell_waddr;
   logic [CELL_W-1:0] cell_wdata;
   logic              cell_we;

   // Edge load stage with forwarding of the previous cycle's write.
   logic              e_vld_ff;
   logic [AW-1:0]     e_addr_ff;
   logic [CELL_W-1:0] e_cap_ff;
   logic              fwd_vld_ff;
   logic [AW-1:0]     fwd_addr_ff;
   logic [CELL_W-1:0] fwd_data_ff;
   logic [CELL_W-1:0] edge_base;
   logic [CELL_W:0]   edge_sum;
   logic [CELL_W-1:0] edge_sat;

   logic [AW-1:0]     clr_ff;

   // Search state.
   logic [MAX_NODES-1:0] seen_ff;
   logic [NW-1:0]        q_mem [MAX_NODES];
   logic [NW-1:0]        q_rd_ff;
   logic [NW-1:0]        par_mem [MAX_NODES];
   logic [NW-1:0]        par_rd_ff;
   logic [CW-1:0]        head_ff;
   logic [CW-1:0]        tail_ff;
   logic [NW-1:0]        u_ff;
   logic [NW-1:0]        v_ff;
   logic [NW-1:0]        w_ff;
   logic [NW-1:0]        p_ff;
   logic [CELL_W-1:0]    best_ff;
   logic [FLOW_W-1:0]    total_ff;
   logic [FLOW_W-1:0]    max_flow_ff;

   logic [CW-1:0]     n_act;
   logic [NW-1:0]     src_idx;
   logic [NW-1:0]     dst_idx;
   logic              edge_ok;
   logic              hit;
   logic [CELL_W:0]   rev_sum;
   logic [FLOW_W:0]   total_sum;

   assign n_act   = (32'(node_count_ff) > 32'(MAX_NODES)) ? CW'(MAX_NODES)
                                                          : CW'(node_count_ff);
   assign src_idx = NW'(src_ff);
   assign dst_idx = NW'(dst_ff);
   assign edge_ok = (32'(req_edge_from) < 32'(n_act)) && (32'(req_edge_to) < 32'(n_act));

   assign edge_base = (fwd_vld_ff && (fwd_addr_ff == e_addr_ff)) ? fwd_data_ff : cell_rd_ff;
   assign edge_sum  = {1'b0, edge_base} + {1'b0, e_cap_ff};
   assign edge_sat  = edge_sum[CELL_W] ? CELL_MAX : edge_sum[CELL_W-1:0];
   assign rev_sum   = {1'b0, cell_rd_ff} + {1'b0, best_ff};
   assign total_sum = {1'b0, total_ff} + (FLOW_W + 1)'(best_ff);

   assign hit = (cell_rd_ff != '0) && !seen_ff[v_ff];

   assign status.clear_done  = &clr_ff;
   assign status.queue_empty = (head_ff == tail_ff);
   assign status.scan_last   = (32'(v_ff) == 32'(n_act) - 32'd1);
   assign status.found       = hit && (v_ff == dst_idx);
   assign status.at_src      = (w_ff == src_idx);
   assign status.trivial     = (src_ff == dst_ff) || (32'(src_ff) >= 32'(n_act)) ||
                               (32'(dst_ff) >= 32'(n_act));

   assign rsp_max_flow = max_flow_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= CSR_DATA_W'(MAX_NODES_DEF);
         src_ff        <= '0;
         dst_ff        <= NODE_FIELD_W'(MAX_NODES_DEF - 1);
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_NODE_COUNT:  node_count_ff <= csr_wdata;
            CSR_SOURCE_NODE: src_ff        <= csr_wdata[NODE_FIELD_W-1:0];
            CSR_SINK_NODE:   dst_ff        <= csr_wdata[NODE_FIELD_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      cell_raddr = '0;
      cell_we    = 1'b0;
      cell_waddr = '0;
      cell_wdata = '0;
      unique case (cmd.op)
         OP_LOAD:    cell_raddr = {NW'(req_edge_from), NW'(req_edge_to)};
         OP_SCAN_RD: cell_raddr = {u_ff, v_ff};
         OP_BN_PW,
         OP_AUG_PW:  cell_raddr = {par_rd_ff, w_ff};
         OP_AUG_W1: begin
            cell_raddr = {w_ff, p_ff};
            cell_we    = 1'b1;
            cell_waddr = {p_ff, w_ff};
            cell_wdata = cell_rd_ff - best_ff;
         end
         OP_AUG_W2: begin
            cell_we    = 1'b1;
            cell_waddr = {w_ff, p_ff};
            cell_wdata = rev_sum[CELL_W] ? CELL_MAX : rev_sum[CELL_W-1:0];
         end
         OP_CLEAR: begin
            cell_we    = 1'b1;
            cell_waddr = clr_ff;
         end
         default: ;
      endcase
      // Edge writes land only while loading, when nothing else writes.
      if (e_vld_ff) begin
         cell_we    = 1'b1;
         cell_waddr = e_addr_ff;
         cell_wdata = edge_sat;
      end
   end

   always_ff @(posedge clock) begin
      if (cell_we) begin
         cell_mem[cell_waddr] <= cell_wdata;
      end
      cell_rd_ff <= cell_mem[cell_raddr];
   end

   always_ff @(posedge clock) begin
      if ((cmd.op == OP_BFS_INIT) || ((cmd.op == OP_SCAN_EV) && hit && !status.found)) begin
         q_mem[(cmd.op == OP_BFS_INIT) ? '0 : tail_ff[NW-1:0]] <=
            (cmd.op == OP_BFS_INIT) ? src_idx : v_ff;
      end
      q_rd_ff <= q_mem[head_ff[NW-1:0]];
   end

   always_ff @(posedge clock) begin
      if ((cmd.op == OP_SCAN_EV) && hit) begin
         par_mem[v_ff] <= u_ff;
      end
      par_rd_ff <= par_mem[w_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e_vld_ff   <= 1'b0;
         fwd_vld_ff <= 1'b0;
         clr_ff     <= '0;
      end else begin
         e_vld_ff   <= cmd.load_fire && edge_ok;
         fwd_vld_ff <= e_vld_ff;
         if (cmd.op == OP_CLEAR) begin
            clr_ff <= clr_ff + AW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      e_addr_ff   <= {NW'(req_edge_from), NW'(req_edge_to)};
      e_cap_ff    <= CELL_W'(req_edge_capacity & CAP_MASK);
      fwd_addr_ff <= e_addr_ff;
      fwd_data_ff <= edge_sat;
   end

   always_ff @(posedge clock) begin
      unique case (cmd.op)
         OP_START: total_ff <= '0;
         OP_BFS_INIT: begin
            seen_ff <= MAX_NODES'(1) << src_idx;
            head_ff <= '0;
            tail_ff <= CW'(1);
         end
         OP_DEQ: begin
            if (!status.queue_empty) begin
               head_ff <= head_ff + CW'(1);
            end
         end
         OP_DEQ_WAIT: begin
            u_ff <= q_rd_ff;
            v_ff <= '0;
         end
         OP_SCAN_EV: begin
            if (hit) begin
               seen_ff[v_ff] <= 1'b1;
            end
            if (status.found) begin
               w_ff    <= dst_idx;
               best_ff <= CELL_MAX;
            end else begin
               if (hit) begin
                  tail_ff <= tail_ff + CW'(1);
               end
               v_ff <= v_ff + NW'(1);
            end
         end
         OP_BN_P: begin
            if (status.at_src) begin
               w_ff <= dst_idx;
            end
         end
         OP_BN_PW,
         OP_AUG_PW: p_ff <= par_rd_ff;
         OP_BN_C: begin
            if (cell_rd_ff < best_ff) begin
               best_ff <= cell_rd_ff;
            end
            w_ff <= p_ff;
         end
         OP_AUG_P: begin
            if (status.at_src) begin
               total_ff <= total_sum[FLOW_W] ? FLOW_MAX : total_sum[FLOW_W-1:0];
            end
         end
         OP_AUG_W2: w_ff <= p_ff;
         OP_FINISH: max_flow_ff <= total_ff;
         default: ;
      endcase
   end

endmodule

/* rtl/mfap_ctrl.sv */
`include "max_flow_augmenting_paths_top_macros.svh"

module mfap_ctrl import mfap_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic          req_last_edge,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   typedef enum logic [4:0] {
      S_CLEAR,
      S_LOAD,
      S_DRAIN,
      S_START,
      S_BFS_INIT,
      S_DEQ,
      S_DEQ_WAIT,
      S_SCAN_RD,
      S_SCAN_EV,
      S_BN_P,
      S_BN_PW,
      S_BN_C,
      S_AUG_P,
      S_AUG_PW,
      S_AUG_W1,
      S_AUG_W2,
      S_FINISH
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      can_post;

   // A new result may be posted once the previous one is taken.
   assign can_post  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_LOAD);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in      = state_ff;
      cmd.op        = OP_IDLE;
      cmd.load_fire = (state_ff == S_LOAD) && req_valid;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.op = OP_CLEAR;
            if (status.clear_done) state_in = S_LOAD;
         end
         S_LOAD: begin
            cmd.op = OP_LOAD;
            if (req_valid && req_last_edge) state_in = S_DRAIN;
         end
         S_DRAIN: state_in = S_START;
         S_START: begin
            cmd.op   = OP_START;
            state_in = status.trivial ? S_FINISH : S_BFS_INIT;
         end
         S_BFS_INIT: begin
            cmd.op   = OP_BFS_INIT;
            state_in = S_DEQ;
         end
         S_DEQ: begin
            cmd.op   = OP_DEQ;
            state_in = status.queue_empty ? S_FINISH : S_DEQ_WAIT;
         end
         S_DEQ_WAIT: begin
            cmd.op   = OP_DEQ_WAIT;
            state_in = S_SCAN_RD;
         end
         S_SCAN_RD: begin
            cmd.op   = OP_SCAN_RD;
            state_in = S_SCAN_EV;
         end
         S_SCAN_EV: begin
            cmd.op = OP_SCAN_EV;
            priority if (status.found)     state_in = S_BN_P;
            else if (status.scan_last)     state_in = S_DEQ;
            else                           state_in = S_SCAN_RD;
         end
         S_BN_P: begin
            cmd.op   = OP_BN_P;
            state_in = status.at_src ? S_AUG_P : S_BN_PW;
         end
         S_BN_PW: begin
            cmd.op   = OP_BN_PW;
            state_in = S_BN_C;
         end
         S_BN_C: begin
            cmd.op   = OP_BN_C;
            state_in = S_BN_P;
         end
         S_AUG_P: begin
            cmd.op   = OP_AUG_P;
            state_in = status.at_src ? S_BFS_INIT : S_AUG_PW;
         end
         S_AUG_PW: begin
            cmd.op   = OP_AUG_PW;
            state_in = S_AUG_W1;
         end
         S_AUG_W1: begin
            cmd.op   = OP_AUG_W1;
            state_in = S_AUG_W2;
         end
         S_AUG_W2: begin
            cmd.op   = OP_AUG_W2;
            state_in = S_AUG_P;
         end
         S_FINISH: begin
            if (can_post) begin
               cmd.op       = OP_FINISH;
               rsp_valid_in = 1'b1;
               state_in     = S_CLEAR;
            end
         end
         default: state_in = S_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `MFAP_ASSERT_NEXT(a_last_edge_drains, clock, reset,
      req_valid && req_ready && req_last_edge, state_ff == S_DRAIN)
   `MFAP_ASSERT_NEXT(a_finish_posts, clock, reset,
      state_ff == S_FINISH && can_post, rsp_valid_ff && state_ff == S_CLEAR)
   `MFAP_ASSERT_SAME(a_no_load_in_clear, clock, reset,
      state_ff == S_CLEAR, !req_ready && cmd.op == OP_CLEAR)

endmodule

/* rtl/max_flow_augmenting_paths_top.sv */
// Channel   Ports                                        Direction
// req       req_valid / req_ready, edge fields           in, one edge per item
// rsp       rsp_valid / rsp_ready, rsp_max_flow          out, one item per last edge
// csr       csr_wr_en, csr_index, csr_wdata              in, write only
//
// Edges load at one per cycle while in the load state; each adds into the
// residual memory through a read stage and a write stage with forwarding
// between back-to-back edges. After the last edge, each search runs a start
// state, dequeue and wait states per node, read and evaluate states per cell,
// then three bottleneck and four update states per path edge; no edge is taken
// meanwhile. After reset and after every result a clearing pass writes one cell
// per cycle over 2**(2*clog2(MAX_NODES)) cells (4096 at 64 nodes); edges wait.
module max_flow_augmenting_paths_top import mfap_pkg::*; #(
   parameter int MAX_NODES     = MAX_NODES_DEF,
   parameter int EDGE_CAP_BITS = EDGE_CAP_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_wr_en,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_wdata,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [NODE_FIELD_W-1:0] req_edge_from,
   input  logic [NODE_FIELD_W-1:0] req_edge_to,
   input  logic [CAP_FIELD_W-1:0]  req_edge_capacity,
   input  logic                    req_last_edge,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [FLOW_W-1:0]       rsp_max_flow
);

   dp_cmd_type    cmd;
   dp_status_type status;

   mfap_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_last_edge (req_last_edge),
      .req_ready     (req_ready),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .status        (status),
      .cmd           (cmd)
   );

   mfap_dp #(
      .MAX_NODES     (MAX_NODES),
      .EDGE_CAP_BITS (EDGE_CAP_BITS)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_edge_from     (req_edge_from),
      .req_edge_to       (req_edge_to),
      .req_edge_capacity (req_edge_capacity),
      .rsp_max_flow      (rsp_max_flow)
   );

endmodule

/* tb/max_flow_augmenting_paths_top_test.sv */
`timescale 1ns / 1ps

module max_flow_augmenting_paths_top_test;
   import mfap_pkg::*;

   localparam int NODES     = 64;
   localparam int SETTLE    = 4400;
   localparam int STALL_MAX = 400000;

   logic                    clock;
   logic                    reset;
   logic                    csr_wr_en;
   logic [CSR_IDX_W-1:0]    csr_index;
   logic [CSR_DATA_W-1:0]   csr_wdata;
   logic                    req_valid;
   logic                    req_ready;
   logic [NODE_FIELD_W-1:0] req_edge_from;
   logic [NODE_FIELD_W-1:0] req_edge_to;
   logic [CAP_FIELD_W-1:0]  req_edge_capacity;
   logic                    req_last_edge;
   logic                    rsp_valid;
   logic                    rsp_ready;
   logic [FLOW_W-1:0]       rsp_max_flow;

   // Own copy of the residual graph and the registers.
   logic [CELL_W-1:0] residual [NODES][NODES];
   int unsigned       path_parent [NODES];
   int unsigned       cfg_nodes;
   int unsigned       cfg_source;
   int unsigned       cfg_sink;

   logic [FLOW_W-1:0] flow_expected [$];
   int                error_count;
   int                idle_pct;
   int                rsp_hold;
   int                quiet_cycles;

   max_flow_augmenting_paths_top DUT (.*);

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic int unsigned nodes_in_use();
      return (cfg_nodes > NODES) ? NODES : cfg_nodes;
   endfunction

   function automatic void clear_graph();
      foreach (residual[i, j]) residual[i][j] = '0;
   endfunction

   // Breadth-first search in ascending neighbor order; returns the bottleneck or 0.
   function automatic longint unsigned find_bottleneck(int unsigned n);
      bit          seen [NODES];
      int unsigned order [NODES];
      int unsigned head;
      int unsigned tail;
      int unsigned u;
      int unsigned w;
      longint unsigned best;
      head = 0;
      tail = 0;
      foreach (seen[i]) seen[i] = 1'b0;
      seen[cfg_source] = 1'b1;
      order[tail++] = cfg_source;
      while (head < tail) begin
         u = order[head++];
         for (int unsigned v = 0; v < n; v++) begin
            if (seen[v] || residual[u][v] == 0) continue;
            seen[v] = 1'b1;
            path_parent[v] = u;
            if (v == cfg_sink) begin
               best = CELL_MAX;
               w = cfg_sink;
               while (w != cfg_source) begin
                  if (residual[path_parent[w]][w] < best) best = residual[path_parent[w]][w];
                  w = path_parent[w];
               end
               return best;
            end
            if (tail < NODES) order[tail++] = v;
         end
      end
      return 0;
   endfunction

   function automatic logic [FLOW_W-1:0] solve_flow();
      int unsigned     n;
      int unsigned     w;
      int unsigned     p;
      longint unsigned f;
      longint unsigned r;
      longint unsigned total;
      n = nodes_in_use();
      total = 0;
      if (cfg_source == cfg_sink || cfg_source >= n || cfg_sink >= n) return '0;
      forever begin
         f = find_bottleneck(n);
         if (f == 0) break;
         total += f;
         w = cfg_sink;
         while (w != cfg_source) begin
            p = path_parent[w];
            r = longint'(residual[w][p]) + f;
            residual[p][w] = residual[p][w] - f;
            residual[w][p] = (r > CELL_MAX) ? CELL_MAX : r;
            w = p;
         end
      end
      return (total > FLOW_MAX) ? FLOW_MAX : total;
   endfunction

   function automatic void apply_edge(int unsigned from, int unsigned to,
                                      longint unsigned cap, bit last);
      longint unsigned   s;
      int unsigned       n;
      logic [FLOW_W-1:0] expect_flow;
      n = nodes_in_use();
      if (from < n && to < n) begin
         s = longint'(residual[from][to]) + cap;
         residual[from][to] = (s > CELL_MAX) ? CELL_MAX : s;
      end
      if (last) begin
         expect_flow = solve_flow();
         flow_expected = {flow_expected, expect_flow};
         clear_graph();
      end
   endfunction

   task automatic send_edge(input int unsigned from, input int unsigned to,
                            input int unsigned cap, input bit last);
      if ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
      req_valid         <= 1'b1;
      req_edge_from     <= from;
      req_edge_to       <= to;
      req_edge_capacity <= cap;
      req_last_edge     <= last;
      do @(posedge clock); while (!req_ready);
      apply_edge(from, to, cap, last);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (flow_expected.size() != 0) @(posedge clock);
   endtask

   // Registers change only when the block is quiet: no result pending and the
   // clearing pass after the last result is over.
   task automatic write_reg(input csr_index_type idx, input int unsigned value);
      drain();
      repeat (SETTLE) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         CSR_NODE_COUNT:  cfg_nodes  = value & 7'h7F;
         CSR_SOURCE_NODE: cfg_source = value & 6'h3F;
         default:         cfg_sink   = value & 6'h3F;
      endcase
      @(posedge clock);
   endtask

   task automatic configure(input int unsigned n, input int unsigned src, input int unsigned snk);
      write_reg(CSR_NODE_COUNT, n);
      write_reg(CSR_SOURCE_NODE, src);
      write_reg(CSR_SINK_NODE, snk);
   endtask

   task automatic random_problem(input int unsigned edges);
      int unsigned n;
      int unsigned a;
      int unsigned b;
      int unsigned cap;
      n = nodes_in_use();
      for (int k = 0; k < edges; k++) begin
         if (n >= 1 && $urandom_range(99) < 85) begin
            a = $urandom_range(n - 1);
            b = $urandom_range(n - 1);
         end else begin
            a = $urandom_range(63);
            b = $urandom_range(63);
         end
         case ($urandom_range(5))
            0:       cap = 0;
            1:       cap = 16'hFFFF;
            2:       cap = $urandom_range(15);
            default: cap = $urandom_range(16'hFFFF);
         endcase
         send_edge(a, b, cap, k == edges - 1);
      end
   endtask

   task automatic test_directed();
      configure(4, 0, 3);
      send_edge(0, 1, 16'hFFFF, 0);
      send_edge(1, 3, 100, 0);
      send_edge(0, 2, 0, 0);
      send_edge(2, 2, 500, 0);
      send_edge(0, 2, 7, 0);
      send_edge(2, 3, 9, 0);
      send_edge(1, 2, 40, 0);
      send_edge(5, 3, 1000, 0);
      send_edge(63, 63, 1, 1);
      send_edge(0, 3, 0, 1);
      configure(64, 0, 63);
      send_edge(0, 63, 16'hFFFF, 0);
      send_edge(0, 32, 16'hAAAA, 0);
      send_edge(32, 63, 16'h5555, 1);
   endtask

   task automatic test_degenerate();
      configure(8, 3, 3);
      send_edge(3, 4, 50, 0);
      send_edge(4, 3, 50, 1);
      configure(8, 2, 9);
      send_edge(2, 7, 50, 1);
      configure(1, 0, 0);
      send_edge(0, 0, 9, 1);
      configure(0, 0, 1);
      send_edge(0, 1, 9, 1);
      configure(127, 63, 0);
      send_edge(63, 0, 123, 1);
   endtask

   // A long back-to-back run of edges into one cell, which saturates.
   task automatic test_cell_saturation();
      configure(2, 0, 1);
      idle_pct = 0;
      for (int k = 0; k < 520; k++) send_edge(0, 1, 16'hFFFF, k == 519);
      idle_pct = 19;
   endtask

   task automatic test_random();
      int unsigned n;
      for (int phase = 0; phase < 8; phase++) begin
         case (phase)
            0:       configure(64, 0, 63);
            1:       configure(2, 0, 1);
            2:       configure(3, 2, 0);
            3:       configure(127, 5, 60);
            default: begin
               n = $urandom_range(4, 16);
               configure(n, $urandom_range(n - 1), $urandom_range(n - 1));
            end
         endcase
         idle_pct = (phase == 4) ? 0 : 19;
         for (int p = 0; p < 2; p++)
            random_problem(nodes_in_use() >= 32 ? $urandom_range(2, 10) : $urandom_range(1, 12));
      end
      idle_pct = 19;
   endtask

   task automatic test_backpressure();
      configure(6, 0, 5);
      rsp_hold = 6000;
      for (int p = 0; p < 4; p++) random_problem(6);
      drain();
      for (int p = 0; p < 3; p++) random_problem(8);
      drain();
   endtask

   // Result checking and receiver stalls.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (flow_expected.size() == 0) begin
               $error("unexpected item: max_flow actual %0d", rsp_max_flow);
               error_count++;
            end else begin
               if (rsp_max_flow !== flow_expected[0]) begin
                  $error("max_flow mismatch: expected %0d actual %0d",
                         flow_expected[0], rsp_max_flow);
                  error_count++;
               end
               void'(flow_expected.pop_front());
            end
         end
         if (rsp_hold > 0) begin
            rsp_hold--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_MAX) begin
         $display("RESULT: ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      reset             <= 1'b1;
      csr_wr_en         <= 1'b0;
      csr_index         <= CSR_NODE_COUNT;
      csr_wdata         <= '0;
      req_valid         <= 1'b0;
      req_edge_from     <= '0;
      req_edge_to       <= '0;
      req_edge_capacity <= '0;
      req_last_edge     <= 1'b0;
      error_count  = 0;
      idle_pct     = 19;
      rsp_hold     = 0;
      cfg_nodes    = 64;
      cfg_source   = 0;
      cfg_sink     = 63;
      clear_graph();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_degenerate();
      test_cell_saturation();
      test_random();
      test_backpressure();
      drain();
      repeat (SETTLE) @(posedge clock);
      if (error_count == 0 && flow_expected.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
